FILE: sv/pig_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pig_pkg
// Shared types, sizes and helpers for the prime implicant generator.
// ----------------------------------------------------------------------------
package pig_pkg;

    localparam int MAX_VARS    = 8;
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CUBE_W      = 8;
    localparam int VC_W        = 4;
    localparam int POP_W       = $clog2(CUBE_W + 1);
    localparam logic [VC_W-1:0] VAR_COUNT_RST = VC_W'(4);

    typedef struct packed {
        logic [CUBE_W-1:0] msk;
        logic [CUBE_W-1:0] val;
    } cube_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        cube_t             wdata;
        logic [IDX_W-1:0]  raddr;
    } ram_req_t;

    typedef struct packed {
        cube_t cube;
        logic  last;
        logic  ovf;
    } prime_t;

    function automatic logic [POP_W-1:0] popcount(input logic [CUBE_W-1:0] x);
        logic [POP_W-1:0] n;
        n = '0;
        for (int b = 0; b < CUBE_W; b++) begin
            n = n + POP_W'(x[b]);
        end
        return n;
    endfunction

    // Live bits: min(var_count, MAX_VARS, cube width) low bits set
    function automatic logic [CUBE_W-1:0] live_mask(input logic [VC_W-1:0] vc);
        logic [CUBE_W-1:0] m;
        m = '0;
        for (int b = 0; b < CUBE_W; b++) begin
            if ((b < MAX_VARS) && (VC_W'(b) < vc)) begin
                m[b] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage
`default_nettype wire

FILE: sv/pig_cube_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pig_cube_ram
// Cube table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pig_cube_ram (
    input  wire logic              aclk,
    input  wire pig_pkg::ram_req_t req,
    output pig_pkg::cube_t         rdata
);

    pig_pkg::cube_t mem [pig_pkg::TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule
`default_nettype wire

FILE: sv/pig_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pig_core
// Sequencer: duplicate scan on load, pairwise merge per dash group,
// containment check and prime hand-off, all through one table read port.
// ----------------------------------------------------------------------------
module pig_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [pig_pkg::VC_W-1:0]    cfg_wr_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [pig_pkg::CUBE_W-1:0]  in_bits,
    input  wire logic [pig_pkg::CUBE_W-1:0]  in_mask,
    input  wire logic                        in_last,
    output pig_pkg::prime_t                  res,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output pig_pkg::ram_req_t                ram_req,
    input  wire pig_pkg::cube_t              ram_rdata
);

    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] S_IDLE    = 5'd0;
    localparam logic [ST_W-1:0] S_DUP_RD  = 5'd1;
    localparam logic [ST_W-1:0] S_DUP_CMP = 5'd2;
    localparam logic [ST_W-1:0] S_DUP_END = 5'd3;
    localparam logic [ST_W-1:0] S_G_START = 5'd4;
    localparam logic [ST_W-1:0] S_I_RD    = 5'd5;
    localparam logic [ST_W-1:0] S_I_CHK   = 5'd6;
    localparam logic [ST_W-1:0] S_J_RD    = 5'd7;
    localparam logic [ST_W-1:0] S_J_CHK   = 5'd8;
    localparam logic [ST_W-1:0] S_E_RD    = 5'd9;
    localparam logic [ST_W-1:0] S_E_LAT   = 5'd10;
    localparam logic [ST_W-1:0] S_C_RD    = 5'd11;
    localparam logic [ST_W-1:0] S_C_CHK   = 5'd12;
    localparam logic [ST_W-1:0] S_E_FOUND = 5'd13;
    localparam logic [ST_W-1:0] S_E_END   = 5'd14;
    localparam logic [ST_W-1:0] S_CLR     = 5'd15;

    localparam int CNT_W = pig_pkg::CNT_W;
    localparam int IDX_W = pig_pkg::IDX_W;
    localparam logic [CNT_W-1:0] DEPTH = CNT_W'(pig_pkg::TABLE_DEPTH);
    localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);
    localparam logic [2:0]       G_LAST = 3'd7;

    logic [ST_W-1:0] state_reg, state_next;
    logic [pig_pkg::VC_W-1:0] var_count_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] gcnt_reg, gcnt_next;
    logic [2:0]       g_reg, g_next;
    logic [CNT_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    pig_pkg::cube_t   ei_reg, ei_next, cand_reg, cand_next, pend_reg, pend_next;
    logic             last_reg, last_next, ret_merge_reg, ret_merge_next;
    logic             ovf_reg, ovf_next, pend_v_reg, pend_v_next;
    logic [pig_pkg::TABLE_DEPTH-1:0] marks_reg, marks_next;

    logic [pig_pkg::CUBE_W-1:0] lm, diff;
    logic                       covered;

    assign lm   = pig_pkg::live_mask(var_count_reg);
    assign diff = ei_reg.val ^ ram_rdata.val;
    // Stored cube (read data) contains the held cube
    assign covered = ((ei_reg.msk & ~ram_rdata.msk) == '0) &&
                     (((ram_rdata.val ^ ei_reg.val) & ~ram_rdata.msk) == '0);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        gcnt_next      = gcnt_reg;
        g_next         = g_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        ei_next        = ei_reg;
        cand_next      = cand_reg;
        pend_next      = pend_reg;
        last_next      = last_reg;
        ret_merge_next = ret_merge_reg;
        ovf_next       = ovf_reg;
        pend_v_next    = pend_v_reg;
        marks_next     = marks_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        res.cube       = pend_reg;
        res.last       = 1'b0;
        res.ovf        = ovf_reg;
        ram_req.we     = 1'b0;
        ram_req.waddr  = count_reg[IDX_W-1:0];
        ram_req.wdata  = cand_reg;
        ram_req.raddr  = k_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cand_next.msk  = in_mask & lm;
                    cand_next.val  = in_bits & lm & ~in_mask;
                    last_next      = in_last;
                    ret_merge_next = 1'b0;
                    k_next         = '0;
                    state_next     = S_DUP_RD;
                end
            end
            S_DUP_RD: begin
                if (k_reg == count_reg) begin
                    state_next = S_DUP_END;
                end else begin
                    state_next = S_DUP_CMP;
                end
            end
            S_DUP_CMP: begin
                if (ram_rdata == cand_reg) begin
                    // duplicate: drop and return
                    if (ret_merge_reg) begin
                        j_next     = j_reg + ONE;
                        state_next = S_J_RD;
                    end else begin
                        state_next = last_reg ? S_G_START : S_IDLE;
                        g_next     = '0;
                    end
                end else begin
                    k_next     = k_reg + ONE;
                    state_next = S_DUP_RD;
                end
            end
            S_DUP_END: begin
                if (count_reg >= DEPTH) begin
                    ovf_next = 1'b1;
                end else begin
                    ram_req.we = 1'b1;
                    marks_next[count_reg[IDX_W-1:0]] = 1'b0;
                    count_next = count_reg + ONE;
                end
                if (ret_merge_reg) begin
                    j_next     = j_reg + ONE;
                    state_next = S_J_RD;
                end else begin
                    state_next = last_reg ? S_G_START : S_IDLE;
                    g_next     = '0;
                end
            end
            S_G_START: begin
                gcnt_next  = count_reg;
                i_next     = '0;
                state_next = S_I_RD;
            end
            S_I_RD: begin
                ram_req.raddr = i_reg[IDX_W-1:0];
                if (i_reg == gcnt_reg) begin
                    if (g_reg == G_LAST) begin
                        i_next     = '0;
                        state_next = S_E_RD;
                    end else begin
                        g_next     = g_reg + 3'd1;
                        state_next = S_G_START;
                    end
                end else begin
                    state_next = S_I_CHK;
                end
            end
            S_I_CHK: begin
                ei_next = ram_rdata;
                if (pig_pkg::popcount(ram_rdata.msk) != pig_pkg::POP_W'(g_reg)) begin
                    i_next     = i_reg + ONE;
                    state_next = S_I_RD;
                end else begin
                    j_next     = i_reg + ONE;
                    state_next = S_J_RD;
                end
            end
            S_J_RD: begin
                ram_req.raddr = j_reg[IDX_W-1:0];
                if (j_reg >= gcnt_reg) begin
                    i_next     = i_reg + ONE;
                    state_next = S_I_RD;
                end else begin
                    state_next = S_J_CHK;
                end
            end
            S_J_CHK: begin
                if ((ram_rdata.msk == ei_reg.msk) &&
                    (pig_pkg::popcount(diff) == pig_pkg::POP_W'(1))) begin
                    marks_next[i_reg[IDX_W-1:0]] = 1'b1;
                    marks_next[j_reg[IDX_W-1:0]] = 1'b1;
                    cand_next.val  = ei_reg.val & ~diff;
                    cand_next.msk  = ei_reg.msk | diff;
                    ret_merge_next = 1'b1;
                    k_next         = '0;
                    state_next     = S_DUP_RD;
                end else begin
                    j_next     = j_reg + ONE;
                    state_next = S_J_RD;
                end
            end
            S_E_RD: begin
                ram_req.raddr = i_reg[IDX_W-1:0];
                if (i_reg == count_reg) begin
                    state_next = S_E_END;
                end else if (marks_reg[i_reg[IDX_W-1:0]]) begin
                    i_next = i_reg + ONE;
                end else begin
                    state_next = S_E_LAT;
                end
            end
            S_E_LAT: begin
                ei_next    = ram_rdata;
                j_next     = '0;
                state_next = S_C_RD;
            end
            S_C_RD: begin
                ram_req.raddr = j_reg[IDX_W-1:0];
                if (j_reg == count_reg) begin
                    state_next = S_E_FOUND;
                end else if ((j_reg == i_reg) || marks_reg[j_reg[IDX_W-1:0]]) begin
                    j_next = j_reg + ONE;
                end else begin
                    state_next = S_C_CHK;
                end
            end
            S_C_CHK: begin
                if (covered) begin
                    i_next     = i_reg + ONE;
                    state_next = S_E_RD;
                end else begin
                    j_next     = j_reg + ONE;
                    state_next = S_C_RD;
                end
            end
            S_E_FOUND: begin
                // hold one prime back so the final one can be flagged
                res_valid = pend_v_reg;
                if (!pend_v_reg || res_ready) begin
                    pend_next   = ei_reg;
                    pend_v_next = 1'b1;
                    i_next      = i_reg + ONE;
                    state_next  = S_E_RD;
                end
            end
            S_E_END: begin
                res_valid = pend_v_reg;
                res.last  = 1'b1;
                if (!pend_v_reg || res_ready) begin
                    state_next = S_CLR;
                end
            end
            S_CLR: begin
                count_next  = '0;
                marks_next  = '0;
                ovf_next    = 1'b0;
                pend_v_next = 1'b0;
                state_next  = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            var_count_reg <= pig_pkg::VAR_COUNT_RST;
            count_reg     <= '0;
            marks_reg     <= '0;
            ovf_reg       <= 1'b0;
            pend_v_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            marks_reg  <= marks_next;
            ovf_reg    <= ovf_next;
            pend_v_reg <= pend_v_next;
            if (cfg_wr_en) begin
                var_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        gcnt_reg      <= gcnt_next;
        g_reg         <= g_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        ei_reg        <= ei_next;
        cand_reg      <= cand_next;
        pend_reg      <= pend_next;
        last_reg      <= last_next;
        ret_merge_reg <= ret_merge_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH)
        else $error("entry count beyond table depth");

    a_write_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_req.we |-> (count_reg < DEPTH))
        else $error("table write with no room");

    a_res_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (state_reg == S_E_FOUND || state_reg == S_E_END))
        else $error("result offered outside emit phase");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLR) |=> (count_reg == '0 && marks_reg == '0 && !ovf_reg))
        else $error("table not cleared after run");

endmodule
`default_nettype wire

FILE: sv/prime_implicant_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prime_implicant_generator
// Quine-McCluskey prime implicant generation over a 64-entry cube table.
// ----------------------------------------------------------------------------
// Input channel s_*: one cube per transfer (value bits, dash mask, last flag).
// Bits at or above var_count are cleared and value bits under dashes zeroed.
// Loading a cube scans the table once for a duplicate through the single
// table read port; s_ready stays low throughout. The cube carrying
// s_last_cube starts the merge phase, which reads pairs within each
// dash-count group, then a containment pass over all unmarked pairs.
// Result channel m_*: one prime per transfer, in table order, the last one
// with m_last_prime; m_table_overflow reports cubes lost to a full table.
// A result register decouples the receiver; a stalled receiver holds the
// sequencer. After the final prime the table is emptied and s_ready returns.
// cfg_wr_en/cfg_wr_data set var_count (reset 4); write only while idle.
// Reset (aresetn low, synchronous) empties the table and drops any result.
// ----------------------------------------------------------------------------
module prime_implicant_generator (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [pig_pkg::VC_W-1:0]   cfg_wr_data,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [pig_pkg::CUBE_W-1:0] s_cube_bits,
    input  wire logic [pig_pkg::CUBE_W-1:0] s_dash_mask,
    input  wire logic                       s_last_cube,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [pig_pkg::CUBE_W-1:0]      m_prime_bits,
    output logic [pig_pkg::CUBE_W-1:0]      m_prime_dash_mask,
    output logic                            m_last_prime,
    output logic                            m_table_overflow
);

    pig_pkg::ram_req_t ram_req;
    pig_pkg::cube_t    ram_rdata;
    pig_pkg::prime_t   res, out_reg;
    logic              res_valid, res_ready, m_valid_reg;

    pig_cube_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    pig_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_bits     (s_cube_bits),
        .in_mask     (s_dash_mask),
        .in_last     (s_last_cube),
        .res         (res),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .ram_req     (ram_req),
        .ram_rdata   (ram_rdata)
    );

    // take a new result when empty or being drained this cycle
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_prime_bits      = out_reg.cube.val;
    assign m_prime_dash_mask = out_reg.cube.msk;
    assign m_last_prime      = out_reg.last;
    assign m_table_overflow  = out_reg.ovf;

endmodule
`default_nettype wire

FILE: sim/prime_implicant_generator_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prime_implicant_generator_test
// Self-checking bench: streams cube functions into the generator, predicts
// the prime implicants of each function and checks every result transfer.
// ----------------------------------------------------------------------------
module prime_implicant_generator_test;

    localparam int HALF_PERIOD = 6;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int CUBE_W = pig_pkg::CUBE_W;
    localparam int VC_W = pig_pkg::VC_W;
    localparam int TABLE_DEPTH = pig_pkg::TABLE_DEPTH;
    localparam int MAX_VARS = pig_pkg::MAX_VARS;

    typedef struct {
        logic [CUBE_W-1:0] bits;
        logic [CUBE_W-1:0] dash;
        logic              last;
    } cube_item_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [VC_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [CUBE_W-1:0] s_cube_bits = '0;
    logic [CUBE_W-1:0] s_dash_mask = '0;
    logic s_last_cube = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [CUBE_W-1:0] m_prime_bits;
    logic [CUBE_W-1:0] m_prime_dash_mask;
    logic m_last_prime;
    logic m_table_overflow;

    always #HALF_PERIOD aclk = ~aclk;

    prime_implicant_generator u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cube_bits       (s_cube_bits),
        .s_dash_mask       (s_dash_mask),
        .s_last_cube       (s_last_cube),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_prime_bits      (m_prime_bits),
        .m_prime_dash_mask (m_prime_dash_mask),
        .m_last_prime      (m_last_prime),
        .m_table_overflow  (m_table_overflow)
    );

    // Cube table model
    logic [CUBE_W-1:0] tbl_val [TABLE_DEPTH];
    logic [CUBE_W-1:0] tbl_msk [TABLE_DEPTH];
    logic              tbl_mark [TABLE_DEPTH];
    int                tbl_cnt = 0;
    logic              tbl_lost = 1'b0;
    logic [VC_W-1:0]   vc_model = pig_pkg::VAR_COUNT_RST;

    cube_item_t      cube_items[$];
    pig_pkg::prime_t prime_q[$];
    int              err_count = 0;
    int              result_count = 0;
    int              item_total = 0;

    function automatic int count_ones(input logic [CUBE_W-1:0] x);
        int n;
        n = 0;
        for (int b = 0; b < CUBE_W; b++) n += x[b];
        return n;
    endfunction

    function automatic void table_insert(input logic [CUBE_W-1:0] v,
                                         input logic [CUBE_W-1:0] m);
        for (int k = 0; k < tbl_cnt; k++) begin
            if (tbl_val[k] == v && tbl_msk[k] == m) return;
        end
        if (tbl_cnt >= TABLE_DEPTH) begin
            tbl_lost = 1'b1;
            return;
        end
        tbl_val[tbl_cnt] = v;
        tbl_msk[tbl_cnt] = m;
        tbl_mark[tbl_cnt] = 1'b0;
        tbl_cnt++;
    endfunction

    function automatic bit contains(input int big, input int sml);
        if ((tbl_msk[sml] & ~tbl_msk[big]) != '0) return 1'b0;
        return ((tbl_val[big] ^ tbl_val[sml]) & ~tbl_msk[big]) == '0;
    endfunction

    function automatic void predict_cube(input cube_item_t it);
        logic [CUBE_W-1:0] lm, msk, val, diff;
        int cnt;
        bit keep;
        pig_pkg::prime_t p;
        int first_new;
        lm = (vc_model >= VC_W'(MAX_VARS)) ? '1 : CUBE_W'((1 << vc_model) - 1);
        msk = it.dash & lm;
        val = it.bits & lm & ~msk;
        table_insert(val, msk);
        if (!it.last) return;
        for (int g = 0; g < CUBE_W; g++) begin
            cnt = tbl_cnt;
            for (int i = 0; i < cnt; i++) begin
                if (count_ones(tbl_msk[i]) != g) continue;
                for (int j = i + 1; j < cnt; j++) begin
                    if (tbl_msk[j] != tbl_msk[i]) continue;
                    diff = tbl_val[i] ^ tbl_val[j];
                    if (count_ones(diff) != 1) continue;
                    tbl_mark[i] = 1'b1;
                    tbl_mark[j] = 1'b1;
                    table_insert(tbl_val[i] & ~diff, tbl_msk[i] | diff);
                end
            end
        end
        first_new = prime_q.size();
        for (int i = 0; i < tbl_cnt; i++) begin
            keep = !tbl_mark[i];
            for (int j = 0; keep && j < tbl_cnt; j++) begin
                if (j != i && !tbl_mark[j] && contains(j, i)) keep = 1'b0;
            end
            if (!keep) continue;
            p.cube.val = tbl_val[i];
            p.cube.msk = tbl_msk[i];
            p.last = 1'b0;
            p.ovf = tbl_lost;
            prime_q = {prime_q, p};
        end
        if (prime_q.size() > first_new) prime_q[prime_q.size() - 1].last = 1'b1;
        tbl_cnt = 0;
        tbl_lost = 1'b0;
        for (int k = 0; k < TABLE_DEPTH; k++) tbl_mark[k] = 1'b0;
    endfunction

    // Sender: bursts and gaps
    int burst_left = 4;
    int gap_left = 0;
    bit drv_busy;
    cube_item_t drv_item;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            drv_busy = s_valid;
            if (s_valid && s_ready) begin
                drv_item.bits = s_cube_bits;
                drv_item.dash = s_dash_mask;
                drv_item.last = s_last_cube;
                predict_cube(drv_item);
                drv_busy = 1'b0;
            end
            if (!drv_busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (cube_items.size() > 0) begin
                    drv_item = cube_items.pop_front();
                    s_valid <= 1'b1;
                    s_cube_bits <= drv_item.bits;
                    s_dash_mask <= drv_item.dash;
                    s_last_cube <= drv_item.last;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern plus two long hold-offs
    int rx_cyc = 0;
    int rx_period = 4;
    int rx_duty = 0;
    int hold_cnt = 0;
    int hold_done = 0;
    pig_pkg::prime_t got;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                result_count++;
                if (prime_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected result bits=%h dash=%h", m_prime_bits,
                                 m_prime_dash_mask);
                end else begin
                    got = prime_q.pop_front();
                    if (got.cube.val !== m_prime_bits || got.cube.msk !== m_prime_dash_mask
                        || got.last !== m_last_prime || got.ovf !== m_table_overflow) begin
                        err_count++;
                        if (err_count <= 10)
                            $display({"mismatch: exp bits=%h dash=%h last=%b ovf=%b,",
                                      " got bits=%h dash=%h last=%b ovf=%b"},
                                     got.cube.val, got.cube.msk, got.last, got.ovf,
                                     m_prime_bits, m_prime_dash_mask, m_last_prime,
                                     m_table_overflow);
                    end
                end
            end
            rx_cyc++;
            if (rx_cyc % 64 == 0) begin
                rx_period = $urandom_range(2, 9);
                rx_duty = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, rx_period - 1);
            end
            // hold off while results pile up and the sender keeps offering
            if ((result_count == 20 && hold_done == 0) ||
                (result_count == 150 && hold_done == 1)) begin
                hold_cnt = 500;
                hold_done++;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (rx_cyc % rx_period) >= rx_duty;
            end
        end
    end

    // Watchdog on cycles without any transfer
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("prime_implicant_generator regression: fail");
            $finish;
        end
    end

    function automatic void add_cube(input logic [CUBE_W-1:0] b, input logic [CUBE_W-1:0] d,
                                     input logic l);
        cube_item_t it;
        it.bits = b;
        it.dash = d;
        it.last = l;
        cube_items = {cube_items, it};
        item_total++;
    endfunction

    task automatic drain();
        @(negedge aclk);
        while (cube_items.size() > 0 || s_valid || prime_q.size() > 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_var_count(input logic [VC_W-1:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        vc_model = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    logic [VC_W-1:0] vc_choices [10] = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd5,
                                         4'd8, 4'd15, 4'd0, 4'd6, 4'd7};
    int fn_size;
    int phase;
    logic [CUBE_W-1:0] rb;

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset value of four variables: single cube, full square, duplicates
        add_cube(8'h00, 8'h00, 1'b1);
        add_cube(8'h00, 8'h00, 1'b0);
        add_cube(8'h01, 8'h00, 1'b0);
        add_cube(8'h02, 8'h00, 1'b0);
        add_cube(8'h02, 8'h00, 1'b0);
        add_cube(8'h03, 8'h00, 1'b1);
        // junk above the live bits and under dashes
        add_cube(8'hff, 8'h00, 1'b0);
        add_cube(8'hff, 8'hf0, 1'b0);
        add_cube(8'hff, 8'hff, 1'b1);
        drain();

        set_var_count(4'd8);
        add_cube(8'hff, 8'h00, 1'b0);
        add_cube(8'h7f, 8'h00, 1'b0);
        add_cube(8'h00, 8'hff, 1'b0);
        add_cube(8'h5a, 8'h81, 1'b1);
        drain();

        set_var_count(4'd0);
        add_cube(8'ha5, 8'h3c, 1'b0);
        add_cube(8'h12, 8'h00, 1'b1);
        drain();

        set_var_count(4'd1);
        add_cube(8'h00, 8'h00, 1'b0);
        add_cube(8'hfe, 8'h00, 1'b0);
        add_cube(8'h01, 8'h00, 1'b1);
        drain();

        // overflow: more distinct cubes than the table holds
        set_var_count(4'd8);
        for (int k = 0; k < 70; k++) add_cube(CUBE_W'(k * 37), 8'h00, k == 69);
        drain();

        phase = 0;
        while (item_total < 270) begin
            set_var_count(vc_choices[phase % 10]);
            for (int f = 0; f < 4; f++) begin
                fn_size = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 16)
                                                      : $urandom_range(1, 7);
                rb = CUBE_W'($urandom_range(0, 255));
                for (int k = 0; k < fn_size; k++) begin
                    // neighbours of a seed cube so that merges happen
                    if ($urandom_range(0, 2) != 0)
                        rb = rb ^ (CUBE_W'(1) << $urandom_range(0, 7));
                    else
                        rb = CUBE_W'($urandom_range(0, 255));
                    add_cube(rb, ($urandom_range(0, 3) == 0) ?
                             CUBE_W'($urandom_range(0, 255) & $urandom_range(0, 255)) : 8'h00,
                             k == fn_size - 1);
                end
            end
            drain();
            phase++;
        end

        if (err_count == 0 && prime_q.size() == 0) begin
            $display("prime_implicant_generator regression: pass");
        end else begin
            $display("prime_implicant_generator regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
